// ===== src/pks_pkg.sv =====
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types, keyword tables and helpers for the priority keyword scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package pks_pkg;

   localparam int MAX_PAYLOAD_DEF = 65535;
   localparam int KW_COUNT        = 8;
   localparam int KW_MAX_LEN      = 6;
   localparam int WIN_DEPTH       = 5;
   localparam int OFS_W           = 16;
   localparam int IDX_W           = 3;

   localparam logic [OFS_W-1:0] RUN_MAX = '1;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
      logic [OFS_W-1:0] offset;
      logic [OFS_W-1:0] length;
   } rpt_type;

   // keyword spellings, lower case, unused tail bytes zero
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"i", "n", "s", "e", "r", "t"},
      '{"s", "e", "l", "e", "c", "t"},
      '{"u", "p", "d", "a", "t", "e"},
      '{"d", "e", "l", "e", "t", "e"},
      '{"a", "l", "t", "e", "r", 8'h00},
      '{"c", "r", "e", "a", "t", "e"},
      '{"d", "r", "o", "p", 8'h00, 8'h00},
      '{"g", "r", "a", "n", "t", 8'h00}
   };

   localparam int KW_LEN [KW_COUNT] = '{6, 6, 6, 6, 5, 6, 4, 5};

   // fold ASCII capitals to lower case
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // printable or newline
   function automatic logic is_text(input logic [7:0] c);
      return (c >= 8'h20 && c <= 8'h7E) || c == 8'h0A;
   endfunction

   // letter expected in window slot i for keyword k (slot 0 most recent)
   function automatic logic [7:0] win_char(input int k, input int i);
      logic [7:0] r;
      r = 8'h00;
      if (i < KW_LEN[k] - 1) begin
         r = KW_TEXT[k][KW_LEN[k] - 2 - i];
      end
      return r;
   endfunction

   // window slot i takes part in keyword k
   function automatic logic win_used(input int k, input int i);
      return i < KW_LEN[k] - 1;
   endfunction

endpackage

`default_nettype wire

// ===== src/pks_window_cell.sv =====
// ----------------------------------------------------------------------------
// pks_window_cell
// One stage of the byte window: holds a folded byte and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module pks_window_cell (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       shift,
   input  wire logic       clear,
   input  wire logic [7:0] byte_in,
   output logic      [7:0] byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_d;

   // empty the window at end of payload, else advance when shift is high
   always_comb begin
      byte_in_d = byte_ff;
      if (clear) begin
         byte_in_d = 8'h00;
      end else if (shift) begin
         byte_in_d = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_d;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

// ===== src/pks_keyword_cell.sv =====
// ----------------------------------------------------------------------------
// pks_keyword_cell
// Tracker for one keyword: first occurrence, offset and text run length.
// Passes the priority report on to the next cell towards keyword 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pks_keyword_cell #(
   parameter int KW = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    load,
   input  wire logic                    clear,
   input  wire logic [7:0]              cur_byte,
   input  wire logic                    cur_text,
   input  wire pks_pkg::win_type        window,
   input  wire logic [pks_pkg::OFS_W-1:0] position,
   input  wire pks_pkg::rpt_type        rpt_in,
   output pks_pkg::rpt_type             rpt_out
);

   import pks_pkg::*;

   localparam int LEN = KW_LEN[KW];
   localparam logic [OFS_W-1:0] LEN_M1 = OFS_W'(LEN - 1);
   localparam logic [OFS_W-1:0] LEN_V  = OFS_W'(LEN);

   logic             seen_ff, seen_in;
   logic             open_ff, open_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [OFS_W-1:0] run_ff, run_in;

   logic             hit;
   logic             upd_seen, upd_open;
   logic [OFS_W-1:0] upd_offset, upd_run;

   // match the keyword ending at the current byte
   always_comb begin
      hit = (position >= LEN_M1) && (cur_byte == KW_TEXT[KW][LEN-1]);
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (win_used(KW, i) && window[i] != win_char(KW, i)) begin
            hit = 1'b0;
         end
      end
   end

   // extend the open run, then record a first occurrence
   always_comb begin
      upd_seen   = seen_ff;
      upd_open   = open_ff;
      upd_offset = offset_ff;
      upd_run    = run_ff;
      if (step) begin
         if (open_ff) begin
            if (cur_text) begin
               if (run_ff != RUN_MAX) begin
                  upd_run = run_ff + 1'b1;
               end
            end else begin
               upd_open = 1'b0;
            end
         end
         if (!seen_ff && hit) begin
            upd_seen   = 1'b1;
            upd_offset = position - LEN_M1;
            upd_run    = LEN_V;
            upd_open   = 1'b1;
         end
      end
   end

   // drop all state at end of payload
   always_comb begin
      seen_in   = upd_seen;
      open_in   = upd_open;
      offset_in = upd_offset;
      run_in    = upd_run;
      if (clear) begin
         seen_in   = 1'b0;
         open_in   = 1'b0;
         offset_in = '0;
         run_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= 1'b0;
         open_ff   <= 1'b0;
         offset_ff <= '0;
         run_ff    <= '0;
      end else if (load) begin
         seen_ff   <= seen_in;
         open_ff   <= open_in;
         offset_ff <= offset_in;
         run_ff    <= run_in;
      end
   end

   // lower index wins: own report overrides what arrives from above
   always_comb begin
      rpt_out = rpt_in;
      if (upd_seen) begin
         rpt_out.found  = 1'b1;
         rpt_out.index  = IDX_W'(KW);
         rpt_out.offset = upd_offset;
         rpt_out.length = upd_run;
      end
   end

endmodule

`default_nettype wire

// ===== src/priority_keyword_scanner_top.sv =====
// ----------------------------------------------------------------------------
// priority_keyword_scanner_top
// Case-insensitive search of a payload for eight keywords, reporting the
// highest-priority one found with its first offset and text run length.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  data_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready  found, keyword_index,
//                                            match_offset, text_length
//
// One byte per cycle while req_ready is high; every cell updates in the cycle the byte is accepted.
// The report for a payload is registered and appears in the cycle after its last byte, and the
// next payload may start in that same cycle if rsp_ready is high.
// Reset clears the window, position and all keyword cells at once.
// A pending report stalls req_ready only while rsp_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_keyword_scanner_top #(
   parameter int MAX_PAYLOAD = pks_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_last_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_found,
   output logic [pks_pkg::IDX_W-1:0]      rsp_keyword_index,
   output logic [pks_pkg::OFS_W-1:0]      rsp_match_offset,
   output logic [pks_pkg::OFS_W-1:0]      rsp_text_length
);

   import pks_pkg::*;

   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD);

   logic             accept, active, step, clear;
   logic [7:0]       cur_byte;
   logic             cur_text;
   logic [POS_W-1:0] pos_ff, pos_in;
   win_type          window;
   rpt_type          chain [KW_COUNT+1];

   logic             rsp_valid_ff, rsp_valid_in;
   rpt_type          rsp_ff;

   // accept while the output register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign active    = pos_ff < POS_MAX;
   assign step      = accept && active;
   assign clear     = accept && req_last_byte;
   assign cur_byte  = fold_case(req_data_byte);
   assign cur_text  = is_text(req_data_byte);

   // count payload bytes, hold at the limit
   always_comb begin
      pos_in = pos_ff;
      if (clear) begin
         pos_in = '0;
      end else if (step) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // byte window as a chain of shift cells
   for (genvar w = 0; w < WIN_DEPTH; w++) begin : g_win
      logic [7:0] src;
      if (w == 0) begin : g_head
         assign src = cur_byte;
      end else begin : g_tail
         assign src = window[w-1];
      end
      pks_window_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (step),
         .clear    (clear),
         .byte_in  (src),
         .byte_out (window[w])
      );
   end

   // keyword cells, report passed from the last keyword towards keyword 0
   assign chain[KW_COUNT] = '0;

   for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
      pks_keyword_cell #(
         .KW (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .load     (accept),
         .clear    (clear),
         .cur_byte (cur_byte),
         .cur_text (cur_text),
         .window   (window),
         .position (OFS_W'(pos_ff)),
         .rpt_in   (chain[k+1]),
         .rpt_out  (chain[k])
      );
   end

   // output register: load on last byte, release when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         rsp_ff <= chain[0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_keyword_index = rsp_ff.index;
   assign rsp_match_offset  = rsp_ff.offset;
   assign rsp_text_length   = rsp_ff.length;

endmodule

`default_nettype wire
